/* hdl/ssdr_pkg.sv */
`default_nettype none

package ssdr_pkg;

  localparam int NUM_SETS        = 2048;
  localparam int NUM_WAYS        = 16;
  localparam int COUNTER_ENTRIES = 64;

  localparam int SET_W    = $clog2(NUM_SETS);
  localparam int WAY_W    = $clog2(NUM_WAYS);
  localparam int SLOT_W   = $clog2(COUNTER_ENTRIES);
  localparam int SIG_W    = 6;
  localparam int RRPV_W   = 2;
  localparam int CNT_W    = 2;
  localparam int EPOCH_W  = 8;
  localparam int PERIOD_W = 16;
  localparam int PC_W     = 64;
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int VICTIM_W = 4;

  localparam int SIG_SHIFT_A = 11;
  localparam int SIG_SHIFT_B = 17;
  localparam int SLOT_SHIFT  = 3;

  typedef logic [RRPV_W-1:0]   rrpv_t;
  typedef logic [SIG_W-1:0]    sig_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [WAY_W-1:0]    way_idx_t;
  typedef logic [SET_W-1:0]    set_idx_t;
  typedef logic [EPOCH_W-1:0]  epoch_t;
  typedef logic [PERIOD_W-1:0] period_t;

  localparam rrpv_t RRPV_MAX       = 2'd3;
  localparam rrpv_t RRPV_RESET     = 2'd2;
  localparam rrpv_t RRPV_FILL_DEAD = 2'd2;
  localparam rrpv_t RRPV_NEAR      = 2'd0;

  localparam cnt_t CNT_MAX   = 2'd3;
  localparam cnt_t CNT_MIN   = 2'd0;
  localparam cnt_t CNT_RESET = 2'd1;
  localparam cnt_t CNT_REUSE = 2'd2;

  localparam period_t PERIOD_RESET = 16'd4096;

  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  typedef struct packed {
    rrpv_t [NUM_WAYS-1:0] rrpv;
    sig_t  [NUM_WAYS-1:0] sig;
  } line_row_t;

  typedef struct packed {
    epoch_t              epoch;
    logic [NUM_WAYS-1:0] dead;
  } dead_row_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_CLEAR,
    S_IDLE,
    S_ROW,
    S_VIC,
    S_PUT,
    S_HIT,
    S_DEC,
    S_RDNEW,
    S_FILL
  } state_t;

  typedef struct packed {
    logic capture;
    logic row_latch;
    logic cnt_old_sel;
    logic cnt_dec;
    logic hit_write;
    logic fill_write;
    logic vic_write;
    logic put;
    logic tick;
    logic sweep;
    logic sweep_lines;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_hit;
    logic way_ok;
    logic sweep_last;
    logic wrap_due;
    logic out_free;
  } status_t;

  function automatic sig_t pc_signature(input logic [PC_W-1:0] pc);
    logic [PC_W-1:0] mix;
    mix = pc ^ (pc >> SIG_SHIFT_A) ^ (pc >> SIG_SHIFT_B);
    return mix[SIG_W-1:0];
  endfunction

  function automatic slot_t counter_slot(input sig_t s);
    sig_t folded;
    folded = s ^ (s >> SLOT_SHIFT);
    return SLOT_W'(folded);
  endfunction

endpackage

`default_nettype wire

/* hdl/ssdr_ram.sv */
`default_nettype none

module ssdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/ssdr_ctrl.sv */
`default_nettype none

module ssdr_ctrl
  import ssdr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state) inside
      S_INIT, S_CLEAR: begin
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        if (status.is_query) begin
          state_next = S_VIC;
        end else if (!status.way_ok) begin
          state_next = S_IDLE;
        end else if (status.is_hit) begin
          state_next = S_HIT;
        end else begin
          state_next = S_DEC;
        end
      end
      S_VIC: state_next = S_PUT;
      S_PUT: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_HIT, S_FILL: begin
        state_next = status.wrap_due ? S_CLEAR : S_IDLE;
      end
      S_DEC:   state_next = S_RDNEW;
      S_RDNEW: state_next = S_FILL;
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state) inside
      S_INIT: begin
        cmd.sweep       = 1'b1;
        cmd.sweep_lines = 1'b1;
      end
      S_CLEAR: cmd.sweep = 1'b1;
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_ROW: begin
        cmd.row_latch   = 1'b1;
        cmd.cnt_old_sel = !status.is_hit;
      end
      S_VIC: cmd.vic_write = 1'b1;
      S_PUT: cmd.put = status.out_free;
      S_HIT: begin
        cmd.hit_write = 1'b1;
        cmd.tick      = 1'b1;
      end
      S_DEC: cmd.cnt_dec = 1'b1;
      S_RDNEW: begin
      end
      S_FILL: begin
        cmd.fill_write = 1'b1;
        cmd.tick       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_capture_reads_row: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_ROW)
    else $error("accepted beat did not move on to the row read");

  a_put_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.put |=> state == S_IDLE)
    else $error("result handed over without returning to idle");

endmodule

`default_nettype wire

/* hdl/ssdr_datapath.sv */
`default_nettype none

module ssdr_datapath
  import ssdr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic                mode,
  input  logic [SET_IN_W-1:0] set_index,
  input  logic [WAY_IN_W-1:0] way,
  input  logic [PC_W-1:0]     pc,
  input  logic                hit,
  input  logic                cfg_write_en,
  input  logic [PERIOD_W-1:0] cfg_write_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VICTIM_W-1:0] victim_way
);

  logic     mode_q;
  set_idx_t set_q;
  way_idx_t way_q;
  logic     way_ok_q;
  sig_t     sig_q;
  logic     hit_q;

  line_row_t           row_q;
  logic [NUM_WAYS-1:0] dead_q;
  slot_t               old_slot_q;
  way_idx_t            victim_q;

  period_t  decay_period;
  period_t  update_count;
  epoch_t   epoch;
  set_idx_t sweep_idx;

  set_idx_t  set_in;
  line_row_t line_rdata, line_wdata, line_reset, row_upd;
  dead_row_t dead_rdata, dead_wdata;
  logic      line_we, dead_we;
  set_idx_t  row_waddr;
  logic [NUM_WAYS-1:0] dead_upd;

  logic [COUNTER_ENTRIES-1:0] cnt_valid;
  logic  cnt_vld_q;
  cnt_t  cnt_rdata, cnt_val, cnt_wdata;
  slot_t cnt_raddr, cnt_waddr, slot_new;
  logic  cnt_we;

  logic [NUM_WAYS-1:0] hi_bits, lo_bits, dead_match;
  logic     top_hi, top_lo, age_needed, dead_found;
  rrpv_t    top, rise;
  rrpv_t    aged [NUM_WAYS];
  line_row_t aged_row;
  way_idx_t dead_sel, aged_sel, vic_sel;

  period_t count_inc;
  logic    period_hit, sweep_last, out_free;

  assign set_in   = set_idx_t'(set_index);
  assign slot_new = counter_slot(sig_q);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= mode;
      set_q    <= set_in;
      way_q    <= WAY_W'(way);
      way_ok_q <= int'(way) < NUM_WAYS;
      sig_q    <= pc_signature(pc);
      hit_q    <= hit;
    end
    if (cmd.row_latch) begin
      row_q      <= line_rdata;
      dead_q     <= (dead_rdata.epoch == epoch) ? dead_rdata.dead : '0;
      old_slot_q <= counter_slot(line_rdata.sig[way_q]);
    end
    if (cmd.vic_write) begin
      victim_q <= vic_sel;
    end
  end

  ssdr_ram #(
    .WIDTH($bits(line_row_t)),
    .DEPTH(NUM_SETS)
  ) u_line_ram (
    .clk  (clk),
    .we   (line_we),
    .waddr(row_waddr),
    .wdata(line_wdata),
    .raddr(set_in),
    .rdata(line_rdata)
  );

  ssdr_ram #(
    .WIDTH($bits(dead_row_t)),
    .DEPTH(NUM_SETS)
  ) u_dead_ram (
    .clk  (clk),
    .we   (dead_we),
    .waddr(row_waddr),
    .wdata(dead_wdata),
    .raddr(set_in),
    .rdata(dead_rdata)
  );

  ssdr_ram #(
    .WIDTH(CNT_W),
    .DEPTH(COUNTER_ENTRIES)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  // Counters never written since reset read as their reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (cnt_we) begin
      cnt_valid[cnt_waddr] <= 1'b1;
    end
    cnt_vld_q <= cnt_valid[cnt_raddr];
  end

  assign cnt_raddr = cmd.cnt_old_sel ? counter_slot(line_rdata.sig[way_q]) : slot_new;
  assign cnt_val   = cnt_vld_q ? cnt_rdata : CNT_RESET;
  assign cnt_we    = cmd.hit_write | cmd.cnt_dec;
  assign cnt_waddr = cmd.cnt_dec ? old_slot_q : slot_new;

  always_comb begin
    if (cmd.cnt_dec) begin
      cnt_wdata = (cnt_val == CNT_MIN) ? CNT_MIN : cnt_val - 1'b1;
    end else begin
      cnt_wdata = (cnt_val == CNT_MAX) ? CNT_MAX : cnt_val + 1'b1;
    end
  end

  always_comb begin
    row_upd  = row_q;
    dead_upd = dead_q;
    if (cmd.hit_write) begin
      row_upd.rrpv[way_q] = RRPV_NEAR;
      dead_upd[way_q]     = 1'b0;
    end
    if (cmd.fill_write) begin
      row_upd.sig[way_q] = sig_q;
      if (cnt_val >= CNT_REUSE || !dead_q[way_q]) begin
        row_upd.rrpv[way_q] = RRPV_NEAR;
        dead_upd[way_q]     = 1'b0;
      end else begin
        row_upd.rrpv[way_q] = RRPV_FILL_DEAD;
        dead_upd[way_q]     = 1'b1;
      end
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      hi_bits[w]    = row_q.rrpv[w][1];
      lo_bits[w]    = row_q.rrpv[w][0];
      dead_match[w] = dead_q[w] && (row_q.rrpv[w] == RRPV_MAX);
    end
    top_hi     = |hi_bits;
    top_lo     = |(lo_bits & (top_hi ? hi_bits : '1));
    top        = {top_hi, top_lo};
    rise       = RRPV_MAX - top;
    age_needed = top != RRPV_MAX;
    dead_found = |dead_match;
    aged_row   = row_q;
    dead_sel   = '0;
    aged_sel   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w]          = row_q.rrpv[w] + rise;
      aged_row.rrpv[w] = aged[w];
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (dead_match[w]) begin
        dead_sel = WAY_W'(w);
      end
      if (aged[w] == RRPV_MAX) begin
        aged_sel = WAY_W'(w);
      end
    end
    vic_sel = dead_found ? dead_sel : aged_sel;
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      line_reset.rrpv[w] = RRPV_RESET;
      line_reset.sig[w]  = '0;
    end
  end

  assign row_waddr = cmd.sweep ? sweep_idx : set_q;
  assign line_we   = (cmd.sweep & cmd.sweep_lines) | cmd.hit_write | cmd.fill_write
                   | (cmd.vic_write & age_needed & !dead_found);
  assign dead_we   = cmd.sweep | cmd.hit_write | cmd.fill_write;

  always_comb begin
    if (cmd.sweep) begin
      line_wdata = line_reset;
    end else if (cmd.vic_write) begin
      line_wdata = aged_row;
    end else begin
      line_wdata = row_upd;
    end
    dead_wdata.epoch = cmd.sweep ? '0 : epoch;
    dead_wdata.dead  = cmd.sweep ? '0 : dead_upd;
  end

  // A global dead-bit clear moves to a new epoch; rows tagged with an older
  // epoch read as having no dead lines.
  assign count_inc  = update_count + 1'b1;
  assign period_hit = count_inc == decay_period;
  assign sweep_last = sweep_idx == SET_W'(NUM_SETS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_period <= PERIOD_RESET;
      update_count <= '0;
      epoch        <= '0;
      sweep_idx    <= '0;
    end else begin
      if (cfg_write_en) begin
        decay_period <= cfg_write_data;
      end
      if (cmd.tick) begin
        if (period_hit) begin
          update_count <= '0;
          epoch        <= epoch + 1'b1;
        end else begin
          update_count <= count_inc;
        end
      end
      if (cmd.sweep) begin
        sweep_idx <= sweep_last ? '0 : sweep_idx + 1'b1;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      victim_way <= VICTIM_W'(victim_q);
    end
  end

  always_comb begin
    status.is_query   = mode_q == MODE_QUERY;
    status.is_hit     = hit_q;
    status.way_ok     = way_ok_q;
    status.sweep_last = sweep_last;
    status.wrap_due   = period_hit && (epoch == '1);
    status.out_free   = out_free;
  end

  a_aged_victim_at_max: assert property (@(posedge clk) disable iff (rst)
    cmd.vic_write && !dead_found |-> aged[aged_sel] == RRPV_MAX)
    else $error("aged victim is not at the distant re-reference value");

  a_count_below_period: assert property (@(posedge clk) disable iff (rst)
    cmd.tick && decay_period != '0 |=> update_count != decay_period)
    else $error("update count reached the decay period without a clear");

  a_put_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> out_free)
    else $error("result register overwritten before its beat was taken");

endmodule

`default_nettype wire

/* hdl/ship_srrip_deadblock_replacement.sv */
`default_nettype none

// SRRIP replacement with a signature reuse predictor and per-line dead bits, for a
// 2048-set, 16-way cache. Each beat is either a victim query, which returns one
// victim_way beat, or a state update, which returns nothing. Line state lives in
// two set-row memories and the 64 reuse counters in a small memory, so one item is
// handled at a time: a hit update does the row read and hit write, a fill update
// the row read, old-counter decrement, new-counter read and fill write (its
// counter reads share one port), and a victim query the row read and victim choice
// before its result is offered. After reset the block writes the reset values into
// every set row before the first beat is accepted. Dead-bit clears are free except
// every 256th, which runs a pass over the dead-bit memory with input stalled.
// The decay period may only be written while no beat is in flight.
module ship_srrip_deadblock_replacement
  import ssdr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [SET_IN_W-1:0] set_index,
  input  logic [WAY_IN_W-1:0] way,
  input  logic [PC_W-1:0]     pc,
  input  logic                hit,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VICTIM_W-1:0] victim_way,
  input  logic                cfg_write_en,
  input  logic [PERIOD_W-1:0] cfg_write_data
);

  cmd_t    cmd;
  status_t status;

  ssdr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  ssdr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .set_index     (set_index),
    .way           (way),
    .pc            (pc),
    .hit           (hit),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .victim_way    (victim_way)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb
  import ssdr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_COUNT  = NUM_SETS * NUM_WAYS;
  localparam int QUIET_LIMIT = 12000;
  localparam int LONG_HOLD   = 400;
  localparam int PC_POOL     = 8;

  typedef struct {
    logic                mode;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way;
    logic [PC_W-1:0]     pc;
    logic                hit;
  } access_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic                mode           = MODE_QUERY;
  logic [SET_IN_W-1:0] set_index      = '0;
  logic [WAY_IN_W-1:0] way            = '0;
  logic [PC_W-1:0]     pc             = '0;
  logic                hit            = 1'b0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [VICTIM_W-1:0] victim_way;
  logic                cfg_write_en   = 1'b0;
  logic [PERIOD_W-1:0] cfg_write_data = '0;

  ship_srrip_deadblock_replacement u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .set_index      (set_index),
    .way            (way),
    .pc             (pc),
    .hit            (hit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .victim_way     (victim_way),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  access_t             pending_accesses[$];
  logic [VICTIM_W-1:0] expected_victims[$];
  logic [PC_W-1:0]     pc_pool[PC_POOL];
  int                  sender_idle_pct    = 0;
  int                  receiver_stall_pct = 0;
  int                  hold_request       = 0;
  int                  failures           = 0;
  int                  quiet_cycles       = 0;
  period_t             decay_period_cfg   = PERIOD_RESET;

  // Replacement state as the block should hold it. Dead bits are stamped with
  // the clear epoch in which they were set, so a global clear is one increment.
  rrpv_t   rrpv_mem[LINE_COUNT];
  sig_t    sig_mem[LINE_COUNT];
  int      dead_epoch[LINE_COUNT];
  cnt_t    reuse_ctr[COUNTER_ENTRIES];
  period_t update_count;
  int      clear_epoch;

  function automatic void reset_replacement_state();
    int i;
    for (i = 0; i < LINE_COUNT; i++) begin
      rrpv_mem[i]   = RRPV_RESET;
      sig_mem[i]    = '0;
      dead_epoch[i] = -1;
    end
    for (i = 0; i < COUNTER_ENTRIES; i++) reuse_ctr[i] = CNT_RESET;
    update_count = '0;
    clear_epoch  = 0;
  endfunction

  function automatic bit line_dead(input int line);
    return dead_epoch[line] == clear_epoch;
  endfunction

  function automatic int reuse_slot(input sig_t s);
    logic [SIG_W-1:0] folded;
    folded = s ^ (s >> 3);
    return int'(folded) % COUNTER_ENTRIES;
  endfunction

  function automatic logic [VICTIM_W-1:0] predict_victim(input int base);
    int    w;
    rrpv_t top;
    top = '0;
    for (w = 0; w < NUM_WAYS; w++)
      if (line_dead(base + w) && rrpv_mem[base + w] == RRPV_MAX) return VICTIM_W'(w);
    for (w = 0; w < NUM_WAYS; w++)
      if (rrpv_mem[base + w] > top) top = rrpv_mem[base + w];
    for (w = 0; w < NUM_WAYS; w++) rrpv_mem[base + w] = rrpv_mem[base + w] + (RRPV_MAX - top);
    for (w = 0; w < NUM_WAYS; w++)
      if (rrpv_mem[base + w] == RRPV_MAX) return VICTIM_W'(w);
    return '0;
  endfunction

  function automatic void apply_line_update(input int line, input logic [PC_W-1:0] addr,
                                            input logic was_hit);
    logic [PC_W-1:0] mixed;
    sig_t            s;
    int              slot;
    int              old_slot;
    mixed = addr ^ (addr >> 11) ^ (addr >> 17);
    s     = mixed[SIG_W-1:0];
    slot  = reuse_slot(s);
    if (was_hit) begin
      rrpv_mem[line]   = RRPV_NEAR;
      dead_epoch[line] = -1;
      if (reuse_ctr[slot] < CNT_MAX) reuse_ctr[slot]++;
    end else begin
      old_slot = reuse_slot(sig_mem[line]);
      if (reuse_ctr[old_slot] > CNT_MIN) reuse_ctr[old_slot]--;
      sig_mem[line] = s;
      if (reuse_ctr[slot] >= CNT_REUSE || !line_dead(line)) begin
        rrpv_mem[line]   = RRPV_NEAR;
        dead_epoch[line] = -1;
      end else begin
        rrpv_mem[line]   = RRPV_FILL_DEAD;
        dead_epoch[line] = clear_epoch;
      end
    end
    update_count = update_count + 1'b1;
    if (update_count == decay_period_cfg) begin
      clear_epoch++;
      update_count = '0;
    end
  endfunction

  always @(posedge clk) begin : driver
    access_t nxt;
    int      base;
    if (rst) begin
      in_valid <= 1'b0;
      reset_replacement_state();
    end else begin
      if (in_valid && !in_stall) begin
        base = (int'(set_index) % NUM_SETS) * NUM_WAYS;
        if (mode == MODE_QUERY) expected_victims.push_back(predict_victim(base));
        else if (int'(way) < NUM_WAYS) apply_line_update(base + int'(way), pc, hit);
      end
      if (!in_valid || !in_stall) begin
        if (pending_accesses.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_accesses.pop_front();
          mode      <= nxt.mode;
          set_index <= nxt.set_index;
          way       <= nxt.way;
          pc        <= nxt.pc;
          hit       <= nxt.hit;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    int                  hold_seen;
    int                  hold_left;
    logic [VICTIM_W-1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_victims.size() == 0) begin
          $error("victim_way: expected no beat, actual %0d", victim_way);
          failures++;
        end else begin
          want = expected_victims.pop_front();
          if (victim_way !== want) begin
            $error("victim_way: expected %0d, actual %0d", want, victim_way);
            failures++;
          end
        end
      end
      if (hold_seen != hold_request) begin
        hold_seen = hold_request;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_access(input logic m, input int s, input int w, input logic [PC_W-1:0] p,
                            input logic h);
    access_t a;
    a.mode      = m;
    a.set_index = SET_IN_W'(s);
    a.way       = WAY_IN_W'(w);
    a.pc        = p;
    a.hit       = h;
    pending_accesses.push_back(a);
  endtask

  // Most traffic goes to a few sets, and half of it to a few PCs, so that hits,
  // fills and ageing keep meeting the same lines and counters.
  task automatic add_random_access();
    int set_pool[6];
    int s;
    logic [PC_W-1:0] p;
    set_pool = '{0, 1, 5, 777, 1024, 2047};
    if ($urandom_range(99) < 80) s = set_pool[$urandom_range(5)];
    else s = $urandom_range(NUM_SETS - 1);
    if ($urandom_range(1) == 0) p = pc_pool[$urandom_range(PC_POOL - 1)];
    else p = {$urandom, $urandom};
    add_access(($urandom_range(99) < 40) ? MODE_QUERY : MODE_UPDATE, s,
               $urandom_range(NUM_WAYS - 1), p, logic'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_accesses.size() != 0 || in_valid || expected_victims.size() != 0);
    repeat (8) @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  task automatic run_phase(input period_t period, input int send_pct, input int recv_pct,
                           input int count, input bit long_hold);
    int i;
    @(posedge clk);
    cfg_write_en     <= 1'b1;
    cfg_write_data   <= period;
    decay_period_cfg = period;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
    if (long_hold) hold_request = hold_request + 1;
    for (i = 0; i < count; i++) add_random_access();
    wait_drained();
  endtask

  initial begin
    int i;
    for (i = 0; i < PC_POOL; i++) pc_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_access(MODE_QUERY,  0,    15, '1, 1'b1);
    add_access(MODE_UPDATE, 0,    0,  '0, 1'b1);
    add_access(MODE_QUERY,  0,    0,  '0, 1'b0);
    add_access(MODE_UPDATE, 0,    15, '1, 1'b0);
    add_access(MODE_UPDATE, 0,    15, '1, 1'b1);
    add_access(MODE_QUERY,  0,    7,  '0, 1'b0);
    add_access(MODE_UPDATE, 2047, 0,  '0, 1'b0);
    add_access(MODE_UPDATE, 2047, 15, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_access(MODE_UPDATE, 2047, 0,  64'h5555_5555_5555_5555, 1'b1);
    add_access(MODE_QUERY,  2047, 0,  '0, 1'b0);
    for (i = 0; i < 4; i++) add_access(MODE_UPDATE, 1, 3, 64'h0000_0000_0002_0841, 1'b1);
    for (i = 0; i < 4; i++) add_access(MODE_UPDATE, 1, 3, 64'h0000_0000_0002_0841, 1'b0);
    add_access(MODE_QUERY,  1,    0,  '0, 1'b0);
    add_access(MODE_QUERY,  1,    0,  '0, 1'b0);
    add_access(MODE_QUERY,  2047, 9,  '1, 1'b1);
    wait_drained();

    run_phase(16'd1,     0,  0,  400, 1'b0);
    run_phase(16'd3,     68, 0,  120, 1'b0);
    run_phase(16'd65535, 0,  68, 120, 1'b0);
    run_phase(16'd20,    33, 33, 120, 1'b0);
    run_phase(16'd0,     0,  0,  100, 1'b1);
    run_phase(16'd4096,  33, 33, 120, 1'b0);

    repeat (50) @(negedge clk);
    if (expected_victims.size() != 0) begin
      $error("victim_way: %0d expected beats never arrived", expected_victims.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/ssdr_pkg.sv
hdl/ssdr_ram.sv
hdl/ssdr_ctrl.sv
hdl/ssdr_datapath.sv
hdl/ship_srrip_deadblock_replacement.sv
test/tb.sv
